// ----- hw/rtl/mmrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmrs_pkg
// Types, register indexes and constants shared by the region scanner.
// ----------------------------------------------------------------------------
package mmrs_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned TYPE_W = 8;

    localparam logic [TYPE_W-1:0] AVAILABLE_TYPE_DEFAULT = 8'd1;

    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SIZE    = 2'd2;

    localparam logic [ADDR_W-1:0] WINDOW_LOW_RESET  = '0;
    localparam logic [ADDR_W-1:0] WINDOW_HIGH_RESET = '1;
    localparam logic [ADDR_W-1:0] MIN_SIZE_RESET    = '0;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_length;
        logic [TYPE_W-1:0] region_type;
        logic              last_entry;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] highest_end;
        logic [ADDR_W-1:0] total_available;
        logic [ADDR_W-1:0] largest_base;
        logic [ADDR_W-1:0] largest_length;
        logic              largest_found;
        logic [ADDR_W-1:0] fit_base;
        logic [ADDR_W-1:0] fit_length;
        logic              fit_found;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] window_low;
        logic [ADDR_W-1:0] window_high;
        logic [ADDR_W-1:0] min_size;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] end_addr;
        logic              avail;
        logic              last;
    } stage_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] clip_start;
        logic [ADDR_W-1:0] clip_end;
        logic              hit;
        logic              avail;
        logic              last;
    } clip_t;

endpackage

// ----- hw/rtl/mmrs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mmrs_cfg_regs
// Window and minimum size registers, loaded through a plain write port.
// ----------------------------------------------------------------------------
module mmrs_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mmrs_pkg::ADDR_W-1:0]         cfg_data,
    output mmrs_pkg::cfg_t                      cfg
);

    mmrs_pkg::cfg_t cfg_reg;
    mmrs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mmrs_pkg::CFG_WINDOW_LOW:  cfg_next.window_low  = cfg_data;
                mmrs_pkg::CFG_WINDOW_HIGH: cfg_next.window_high = cfg_data;
                mmrs_pkg::CFG_MIN_SIZE:    cfg_next.min_size    = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low  <= mmrs_pkg::WINDOW_LOW_RESET;
            cfg_reg.window_high <= mmrs_pkg::WINDOW_HIGH_RESET;
            cfg_reg.min_size    <= mmrs_pkg::MIN_SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/mmrs_front.sv -----
// ----------------------------------------------------------------------------
// mmrs_front
// Input register with region end, then window clipping register.
// ----------------------------------------------------------------------------
module mmrs_front
#(
    parameter logic [mmrs_pkg::TYPE_W-1:0] AVAILABLE_TYPE = mmrs_pkg::AVAILABLE_TYPE_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mmrs_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  mmrs_pkg::entry_t    in_data,
    output logic                clip_valid,
    input  logic                clip_ready,
    output mmrs_pkg::clip_t     clip
);

    logic                stage_valid_reg;
    mmrs_pkg::stage_t    stage_reg;
    mmrs_pkg::stage_t    stage_next;
    logic                clip_valid_reg;
    mmrs_pkg::clip_t     clip_reg;
    mmrs_pkg::clip_t     clip_next;
    logic                stage_load;
    logic                clip_load;

    assign clip_load  = !clip_valid_reg || clip_ready;
    assign stage_load = !stage_valid_reg || clip_load;
    assign in_ready   = stage_load;

    always_comb
    begin
        stage_next.base     = in_data.region_base;
        stage_next.length   = in_data.region_length;
        stage_next.end_addr = in_data.region_base + in_data.region_length;
        stage_next.avail    = (in_data.region_type == AVAILABLE_TYPE);
        stage_next.last     = in_data.last_entry;
    end

    always_comb
    begin
        clip_next.base       = stage_reg.base;
        clip_next.length     = stage_reg.length;
        clip_next.end_addr   = stage_reg.end_addr;
        clip_next.avail      = stage_reg.avail;
        clip_next.last       = stage_reg.last;
        clip_next.hit        = !((stage_reg.end_addr <= cfg.window_low)
                                 || (stage_reg.base >= cfg.window_high));
        clip_next.clip_start = (stage_reg.base > cfg.window_low) ? stage_reg.base
                                                                 : cfg.window_low;
        clip_next.clip_end   = (stage_reg.end_addr < cfg.window_high)
                               ? stage_reg.end_addr : cfg.window_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            clip_valid_reg  <= 1'b0;
        end
        else
        begin
            if (stage_load)
            begin
                stage_valid_reg <= in_valid;
            end
            if (clip_load)
            begin
                clip_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load && in_valid)
        begin
            stage_reg <= stage_next;
        end
        if (clip_load && stage_valid_reg)
        begin
            clip_reg <= clip_next;
        end
    end

    assign clip_valid = clip_valid_reg;
    assign clip       = clip_reg;

endmodule

// ----- hw/rtl/mmrs_accum.sv -----
// ----------------------------------------------------------------------------
// mmrs_accum
// Running summaries and result register; clears on the last entry.
// ----------------------------------------------------------------------------
module mmrs_accum
(
    input  logic                clk,
    input  logic                rst_n,
    input  mmrs_pkg::cfg_t      cfg,
    input  logic                clip_valid,
    output logic                clip_ready,
    input  mmrs_pkg::clip_t     clip,
    output logic                out_valid,
    input  logic                out_ready,
    output mmrs_pkg::result_t   out_data
);

    mmrs_pkg::result_t  acc_reg;
    mmrs_pkg::result_t  acc_next;
    mmrs_pkg::result_t  upd;
    logic               out_valid_reg;
    mmrs_pkg::result_t  out_reg;
    logic               fire;
    logic               out_free;
    logic [mmrs_pkg::ADDR_W:0] clip_diff;
    logic [mmrs_pkg::ADDR_W-1:0] clip_len;
    logic               clip_pos;
    logic               fit_take;

    assign out_free   = !out_valid_reg || out_ready;
    assign clip_ready = !clip.last || out_free;
    assign fire       = clip_valid && clip_ready;

    assign clip_diff = {1'b0, clip.clip_end} - {1'b0, clip.clip_start};
    assign clip_pos  = !clip_diff[mmrs_pkg::ADDR_W] && (clip_diff != '0);
    assign clip_len  = clip_diff[mmrs_pkg::ADDR_W-1:0];
    assign fit_take  = clip.avail && clip.hit && clip_pos
                       && (clip_len >= cfg.min_size) && (clip_len > acc_reg.fit_length);

    always_comb
    begin
        upd = acc_reg;
        if (clip.end_addr > acc_reg.highest_end)
        begin
            upd.highest_end = clip.end_addr;
        end
        if (clip.avail)
        begin
            upd.total_available = acc_reg.total_available + clip.length;
            if (clip.length > acc_reg.largest_length)
            begin
                upd.largest_base   = clip.base;
                upd.largest_length = clip.length;
                upd.largest_found  = 1'b1;
            end
        end
        if (fit_take)
        begin
            upd.fit_base   = clip.clip_start;
            upd.fit_length = clip_len;
            upd.fit_found  = 1'b1;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (fire)
        begin
            acc_next = clip.last ? '0 : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (fire && clip.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && clip.last)
        begin
            out_reg <= upd;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hw/rtl/memory_map_region_scanner.sv -----
// ----------------------------------------------------------------------------
// memory_map_region_scanner
// Scans memory map entries and reports end, total, largest and best fit.
//
//   channel   signals                            transfer
//   in        in_valid / in_ready / in_data      one map entry
//   out       out_valid / out_ready / out_data   one summary per last entry
//   cfg       cfg_write / cfg_index / cfg_data   one register write
//
// One entry per cycle, sustained unless a stalled result holds a last entry.
// A last entry passes the input register with end adder, the clip register
// and the result register. Reset clears all summaries and loads the register
// defaults. A stalled result holds only the last-entry step; others flow on.
// ----------------------------------------------------------------------------
module memory_map_region_scanner
#(
    parameter logic [mmrs_pkg::TYPE_W-1:0] AVAILABLE_TYPE = mmrs_pkg::AVAILABLE_TYPE_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mmrs_pkg::entry_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mmrs_pkg::result_t                   out_data,
    input  logic                                cfg_write,
    input  logic [mmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mmrs_pkg::ADDR_W-1:0]         cfg_data
);

    mmrs_pkg::cfg_t     cfg;
    logic               clip_valid;
    logic               clip_ready;
    mmrs_pkg::clip_t    clip;

    mmrs_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mmrs_front
    #(
        .AVAILABLE_TYPE (AVAILABLE_TYPE)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .clip_valid (clip_valid),
        .clip_ready (clip_ready),
        .clip       (clip)
    );

    mmrs_accum u_accum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .clip_valid (clip_valid),
        .clip_ready (clip_ready),
        .clip       (clip),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
